@@ hdl/dns_name_label_encoder_defines.svh @@
// Assertion macros for the DNS name label encoder checker.
// Standalone header; no dependencies.
`ifndef DNS_NAME_LABEL_ENCODER_DEFINES_SVH
`define DNS_NAME_LABEL_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define DNSLE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dnsle: implication failed");

// Next-cycle implication, disabled while reset is asserted
`define DNSLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dnsle: next-cycle implication failed");

`endif

@@ hdl/dnsle_pkg.sv @@
// Shared types and constants of the DNS name label encoder.
// No dependencies.
`default_nettype none

package dnsle_pkg;

  // label store depth and length counter width
  localparam int unsigned MAX_LABEL = 62;
  localparam int unsigned LEN_W     = $clog2(MAX_LABEL + 1);

  localparam logic [7:0] DOT_CHAR  = 8'h2E;
  localparam logic [7:0] TERM_BYTE = 8'h00;

  // result tuser bit positions
  localparam int unsigned TUSER_DONE = 0;
  localparam int unsigned TUSER_OVF  = 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LEN  = 4'b0010,
    S_CHR  = 4'b0100,
    S_TERM = 4'b1000
  } state_e;

  // per-cell control
  typedef struct packed {
    logic wr;     // capture the incoming character
    logic shift;  // take the right neighbor's byte
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/dnsle_cell.sv @@
// One byte cell of the label store chain.
// Depends on dnsle_pkg.
`default_nettype none

module dnsle_cell (
  input  wire                     clk_i,
  input  wire dnsle_pkg::cell_ctrl_t ctrl_i,
  input  wire  [7:0]              wr_data_i,
  input  wire  [7:0]              nbr_data_i,
  output logic [7:0]              data_o
);
  import dnsle_pkg::*;

  logic [7:0] data_q;
  logic [7:0] data_d;

  // shift toward the head during readout, load on a write
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift) begin
      data_d = nbr_data_i;
    end else if (ctrl_i.wr) begin
      data_d = wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ hdl/dns_name_label_encoder.sv @@
// Top level of the DNS name label encoder: control FSM, chain of byte cells,
// output register. Depends on dnsle_pkg and dnsle_cell.
//
//  channel  | dir | tdata         | tuser                        | tlast
//  s_axis   | in  | host_char[7:0]| [0] name_end                 | -
//  m_axis   | out | out_byte[7:0] | [0] name_done [1] label_ovf  | run_last
//
// An ordinary character is written into the cell at the label length, or sets
// the overflow flag once MAX_LABEL bytes are stored. A dot or closing item
// emits the length byte, the stored bytes and, when closing, the terminator,
// one result per cycle while the chain shifts each byte to the head cell;
// output back-pressure stalls emission. Input is not taken while emitting.
// Reset (rst_ni low, asynchronous) clears control state; cells are not reset.
`default_nettype none

module dns_name_label_encoder (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] host_char
  input  wire  [0:0]  s_axis_tuser_i,   // [0] name_end
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tlast_o,
  output logic [1:0]  m_axis_tuser_o    // [0] name_done, [1] label_overflow
);
  import dnsle_pkg::*;

  state_e           state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic             ovf_q, ovf_d;
  logic             end_q, end_d;

  logic             m_valid_q, m_valid_d;
  logic [7:0]       m_data_q, m_data_d;
  logic             m_last_q, m_last_d;
  logic             m_done_q, m_done_d;
  logic             m_ovf_q, m_ovf_d;

  logic             s_fire;
  logic             out_free;
  logic             is_dot;
  logic             store_en;
  logic             shift_en;
  logic [7:0]       cell_data [MAX_LABEL];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign is_dot          = (s_axis_tdata_i == DOT_CHAR);
  assign store_en        = s_fire && !s_axis_tuser_i[0] && !is_dot &&
                           (len_q < LEN_W'(MAX_LABEL));
  assign shift_en        = (state_q == S_CHR) && out_free;

  // chain of cells; cell 0 is the head that feeds the output
  for (genvar i = 0; i < MAX_LABEL; i++) begin : g_cell
    cell_ctrl_t ctrl;
    logic [7:0] nbr;

    assign ctrl.wr    = store_en && (len_q == LEN_W'(i));
    assign ctrl.shift = shift_en;

    if (i < MAX_LABEL - 1) begin : g_mid
      assign nbr = cell_data[i+1];
    end else begin : g_tail
      assign nbr = cell_data[i];
    end

    dnsle_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .wr_data_i  (s_axis_tdata_i),
      .nbr_data_i (nbr),
      .data_o     (cell_data[i])
    );
  end

  // control: collect characters, then walk out length, bytes, terminator
  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    rem_d     = rem_q;
    ovf_d     = ovf_q;
    end_d     = end_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    m_done_d  = m_done_q;
    m_ovf_d   = m_ovf_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser_i[0] || is_dot) begin
            end_d   = s_axis_tuser_i[0];
            state_d = S_LEN;
          end else if (store_en) begin
            len_d = len_q + LEN_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      S_LEN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = 8'(len_q);
          m_last_d  = !end_q && (len_q == '0);
          m_done_d  = 1'b0;
          m_ovf_d   = ovf_q;
          rem_d     = len_q;
          if (len_q != '0) begin
            state_d = S_CHR;
          end else if (end_q) begin
            state_d = S_TERM;
          end else begin
            state_d = S_IDLE;
            ovf_d   = 1'b0;
          end
        end
      end
      S_CHR: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = cell_data[0];
          m_last_d  = !end_q && (rem_q == LEN_W'(1));
          m_done_d  = 1'b0;
          m_ovf_d   = ovf_q;
          rem_d     = rem_q - LEN_W'(1);
          if (rem_q == LEN_W'(1)) begin
            len_d = '0;
            if (end_q) begin
              state_d = S_TERM;
            end else begin
              state_d = S_IDLE;
              ovf_d   = 1'b0;
            end
          end
        end
      end
      S_TERM: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = TERM_BYTE;
          m_last_d  = 1'b1;
          m_done_d  = 1'b1;
          m_ovf_d   = ovf_q;
          ovf_d     = 1'b0;
          len_d     = '0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      ovf_q     <= ovf_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    end_q    <= end_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
    m_done_q <= m_done_d;
    m_ovf_q  <= m_ovf_d;
  end

  assign m_axis_tvalid_o            = m_valid_q;
  assign m_axis_tdata_o             = m_data_q;
  assign m_axis_tlast_o             = m_last_q;
  assign m_axis_tuser_o[TUSER_DONE] = m_done_q;
  assign m_axis_tuser_o[TUSER_OVF]  = m_ovf_q;

endmodule

`default_nettype wire

@@ hdl/dnsle_checker.sv @@
// Port-level checks for the DNS name label encoder, bound to the top level.
// Depends on dns_name_label_encoder_defines.svh and dns_name_label_encoder.
`default_nettype none

`include "dns_name_label_encoder_defines.svh"

module dnsle_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       s_axis_tready_o,
  input wire       m_axis_tvalid_o,
  input wire       m_axis_tready_i,
  input wire [7:0] m_axis_tdata_o,
  input wire       m_axis_tlast_o,
  input wire [1:0] m_axis_tuser_o
);

  // a terminator always closes the run and carries a zero byte
  `DNSLE_ASSERT_IMPLY(a_done_last, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tlast_o)
  `DNSLE_ASSERT_IMPLY(a_done_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o == 8'h00)

  // no new input is taken while a run still has results to send
  `DNSLE_ASSERT_IMPLY(a_no_take_mid_run, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tlast_o, !s_axis_tready_o)

  // a stalled transaction holds its payload
  `DNSLE_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))

endmodule

bind dns_name_label_encoder dnsle_checker u_dnsle_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

@@ test/tb_dns_name_label_encoder.sv @@
// Self-checking testbench for dns_name_label_encoder: streams dotted host names
// in, predicts the DNS wire label bytes, and checks every result transaction.
// Depends on dnsle_pkg and the dns_name_label_encoder RTL.
`default_nettype none

module tb_dns_name_label_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import dnsle_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned NAME_ITEMS  = 420;
  localparam int unsigned DRAIN_WAIT  = 16;
  localparam int unsigned MAX_WAIT    = 13;

  // one host name character or a closing item, plus the sender's wait
  typedef struct {
    logic [7:0] host_char;
    logic       name_end;
    int         wait_cyc;
  } name_item_t;

  // one encoded wire byte with its flags
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       name_done;
    logic       label_ovf;
  } wire_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;   // [7:0] host_char
  logic [0:0] s_axis_tuser_i;   // [0] name_end
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;   // [7:0] out_byte
  logic       m_axis_tlast_o;
  logic [1:0] m_axis_tuser_o;   // [0] name_done, [1] label_overflow

  dns_name_label_encoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  name_item_t pending_names[$];
  wire_byte_t wire_bytes_due[$];

  // label encoder shadow state
  logic [7:0] label_buf[dnsle_pkg::MAX_LABEL];
  int         label_len;
  logic       label_trunc;

  int   n_items;
  int   n_errors;
  int   n_bytes;
  int   cycle_cnt;
  int   tx_burst;
  int   rx_burst;
  int   rx_left;
  bit   have_item;
  bit   in_taken;
  bit   out_taken;
  name_item_t cur_item;

  // Draw a wait of 0..MAX_WAIT, with occasional stretches of no waiting.
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      burst = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == DOT_CHAR);
    return c;
  endfunction

  task automatic push_item(input logic [7:0] ch, input logic fin);
    name_item_t it;
    it.host_char = ch;
    it.name_end  = fin;
    it.wait_cyc  = draw_wait(tx_burst);
    pending_names.push_back(it);
    n_items++;
  endtask

  task automatic push_label(input int len);
    for (int i = 0; i < len; i++) push_item(label_char(), 1'b0);
  endtask

  // Build one well-formed name; first_len >= 0 forces the first label's length.
  task automatic push_name(input int first_len);
    int n_labels;
    int len;
    int sel;
    n_labels = $urandom_range(1, 4);
    for (int l = 0; l < n_labels; l++) begin
      sel = $urandom_range(0, 19);
      if (l == 0 && first_len >= 0) len = first_len;
      else if (sel == 0) len = $urandom_range(55, 75);
      else if (sel == 1) len = 0;
      else len = $urandom_range(1, 12);
      push_label(len);
      if (l != n_labels - 1) push_item(DOT_CHAR, 1'b0);
    end
    // close: mostly a plain end, sometimes a trailing dot or a dangling dot
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      push_item(DOT_CHAR, 1'b0);
    end else begin
      if (sel == 1) push_item(DOT_CHAR, 1'b0);
      push_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Encode one accepted item into the wire bytes it produces.
  task automatic encode_item(input logic [7:0] ch, input logic fin);
    wire_byte_t wb;
    if (fin || ch == DOT_CHAR) begin
      wb.out_byte  = 8'(label_len);
      wb.run_last  = !fin && label_len == 0;
      wb.name_done = 1'b0;
      wb.label_ovf = label_trunc;
      wire_bytes_due.push_back(wb);
      for (int k = 0; k < label_len; k++) begin
        wb.out_byte = label_buf[k];
        wb.run_last = !fin && k == label_len - 1;
        wire_bytes_due.push_back(wb);
      end
      if (fin) begin
        wb.out_byte  = TERM_BYTE;
        wb.run_last  = 1'b1;
        wb.name_done = 1'b1;
        wire_bytes_due.push_back(wb);
      end
      label_len   = 0;
      label_trunc = 1'b0;
    end else if (label_len < dnsle_pkg::MAX_LABEL) begin
      label_buf[label_len] = ch;
      label_len++;
    end else begin
      label_trunc = 1'b1;
    end
  endtask

  task automatic report_error(input string msg);
    $display("%0t ERROR: %s", $realtime, msg);
    n_errors++;
  endtask

  // Drive the input stream at the falling edge.
  always @(negedge clk_i) begin
    logic nv;
    nv = 1'b0;
    if (rst_ni) begin
      if (in_taken) begin
        in_taken  = 1'b0;
        have_item = 1'b0;
      end
      if (!have_item && pending_names.size() != 0) begin
        cur_item  = pending_names.pop_front();
        have_item = 1'b1;
      end
      if (have_item) begin
        if (cur_item.wait_cyc != 0) cur_item.wait_cyc--;
        else nv = 1'b1;
      end
      s_axis_tvalid_i <= nv;
      s_axis_tdata_i  <= cur_item.host_char;
      s_axis_tuser_i  <= cur_item.name_end;
    end
  end

  // Drive output back-pressure at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        out_taken = 1'b0;
        rx_left   = draw_wait(rx_burst);
      end
      m_axis_tready_i <= (rx_left == 0);
      if (rx_left != 0) rx_left--;
    end
  end

  // Sample transactions at the rising edge: check results, then encode inputs.
  always @(posedge clk_i) begin
    wire_byte_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        out_taken = 1'b1;
        if (wire_bytes_due.size() == 0) begin
          report_error($sformatf("unexpected result byte %02h", m_axis_tdata_o));
        end else begin
          want = wire_bytes_due.pop_front();
          if (m_axis_tdata_o !== want.out_byte)
            report_error($sformatf("byte %0d: out_byte %02h, want %02h",
                                   n_bytes, m_axis_tdata_o, want.out_byte));
          if (m_axis_tlast_o !== want.run_last)
            report_error($sformatf("byte %0d: tlast %b, want %b",
                                   n_bytes, m_axis_tlast_o, want.run_last));
          if (m_axis_tuser_o[TUSER_DONE] !== want.name_done)
            report_error($sformatf("byte %0d: name_done %b, want %b",
                                   n_bytes, m_axis_tuser_o[TUSER_DONE], want.name_done));
          if (m_axis_tuser_o[TUSER_OVF] !== want.label_ovf)
            report_error($sformatf("byte %0d: label_overflow %b, want %b",
                                   n_bytes, m_axis_tuser_o[TUSER_OVF], want.label_ovf));
        end
        n_bytes++;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_taken = 1'b1;
        encode_item(s_axis_tdata_i, s_axis_tuser_i[0]);
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_dns_name_label_encoder NOT OK");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tuser_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    label_len       = 0;
    label_trunc     = 1'b0;
    n_items         = 0;
    n_errors        = 0;
    n_bytes         = 0;
    cycle_cnt       = 0;
    tx_burst        = 0;
    rx_burst        = 0;
    rx_left         = 0;
    have_item       = 1'b0;
    in_taken        = 1'b0;
    out_taken       = 1'b0;

    // directed: empty name, lone dot, ignored char on close
    push_item(8'h00, 1'b1);
    push_item(DOT_CHAR, 1'b0);
    push_item(DOT_CHAR, 1'b1);
    // zero and all-ones characters inside a label
    push_item(8'h61, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(DOT_CHAR, 1'b0);
    push_item(8'h62, 1'b0);
    push_item(8'hFF, 1'b1);
    // consecutive dots, then a trailing dot before the close
    push_item(DOT_CHAR, 1'b0);
    push_item(DOT_CHAR, 1'b0);
    push_item(8'h2D, 1'b0);
    push_item(DOT_CHAR, 1'b0);
    push_item(8'h55, 1'b1);
    push_item(8'h7F, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'h01, 1'b0);
    push_item(8'hAA, 1'b1);

    // full label store, then labels that overflow it
    push_name(dnsle_pkg::MAX_LABEL);
    push_name(dnsle_pkg::MAX_LABEL + 1);
    push_label(70);
    push_item(DOT_CHAR, 1'b0);
    push_label(64);
    push_item(8'h00, 1'b1);

    // random: mostly well-formed names, some loose noise items
    while (n_items < NAME_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 3) == 0) push_item(8'($urandom_range(0, 255)), 1'b1);
        else if ($urandom_range(0, 2) == 0) push_item(DOT_CHAR, 1'b0);
        else push_item(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        push_name(-1);
      end
    end
    push_item(8'h00, 1'b1);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // drain: all items accepted, every byte seen, then a settle window
    while (pending_names.size() != 0 || have_item) @(posedge clk_i);
    while (wire_bytes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("tb_dns_name_label_encoder OK");
    end else begin
      $display("tb_dns_name_label_encoder NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hdl
hdl/dnsle_pkg.sv
hdl/dnsle_cell.sv
hdl/dns_name_label_encoder.sv
hdl/dnsle_checker.sv
test/tb_dns_name_label_encoder.sv
